@@ hdl/swtt_pkg.sv @@
`timescale 1ns / 1ps

package swtt_pkg;

  localparam int TIMER_COUNT_DEF = 8;
  localparam int TIME_WIDTH_DEF  = 32;

  typedef enum logic [2:0] {
    CMD_TICK         = 3'd0,
    CMD_SET_INTERVAL = 3'd1,
    CMD_START        = 3'd2,
    CMD_STOP         = 3'd3,
    CMD_CHECK        = 3'd4,
    CMD_ELAPSED      = 3'd5
  } cmd_t;

endpackage

@@ hdl/software_timer_table.sv @@
`timescale 1ns / 1ps

// channel   | ports                                            | handshake
// ----------+--------------------------------------------------+--------------------
// command   | command, timer_index, interval_value             | start high, busy low
// result    | expired, elapsed_time, current_time              | done, one cycle
//
// each command word passes through memory read, execute and write back, and
// result before the result strobe is shown; a new word is taken in the cycle
// the result is shown, so a new word waits until the last one is through
// the interval and end memories each have one read and one write port; only
// one command is in flight, so a write always lands before the next read
// reset clears all control state and the valid bits of both memories at once
// the result cannot be stalled; done marks it for exactly one cycle

module software_timer_table #(
  parameter int TIMER_COUNT = swtt_pkg::TIMER_COUNT_DEF,
  parameter int TIME_WIDTH  = swtt_pkg::TIME_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  command,
  input  logic [2:0]  timer_index,
  input  logic [31:0] interval_value,
  output logic        done,
  output logic        expired,
  output logic [31:0] elapsed_time,
  output logic [31:0] current_time
);

  localparam int IDX_W = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } state_t;

  state_t                 state;
  logic [2:0]             cmd_r;
  logic [IDX_W-1:0]       addr_r;
  logic                   in_range_r;
  logic [TIME_WIDTH-1:0]  ival_r;
  logic                   half_tick;
  logic [TIME_WIDTH-1:0]  time_count;
  logic [TIME_WIDTH-1:0]  base_time;
  logic                   expired_r;

  logic [TIME_WIDTH-1:0]  interval_mem [TIMER_COUNT];
  logic [TIME_WIDTH-1:0]  end_mem      [TIMER_COUNT];
  logic [TIMER_COUNT-1:0] interval_vld;
  logic [TIMER_COUNT-1:0] end_vld;
  logic [TIMER_COUNT-1:0] wrap_flags;
  logic [TIME_WIDTH-1:0]  rd_interval;
  logic [TIME_WIDTH-1:0]  rd_end;
  logic                   rd_interval_vld;
  logic                   rd_end_vld;

  logic                   accept;
  logic [IDX_W-1:0]       addr_in;
  logic                   in_range_in;
  logic [TIME_WIDTH-1:0]  cur_interval;
  logic [TIME_WIDTH-1:0]  cur_end;
  logic [TIME_WIDTH:0]    start_sum;
  logic                   exec;
  logic                   wr_interval;
  logic                   wr_end;
  logic [TIME_WIDTH-1:0]  end_wdata;

  assign busy        = (state != S_IDLE);
  assign accept      = start && !busy;
  assign addr_in     = IDX_W'(timer_index);
  assign in_range_in = (32'(timer_index) < TIMER_COUNT);
  assign exec        = (state == S_EXEC) && in_range_r;

  assign cur_interval = rd_interval_vld ? rd_interval : '0;
  assign cur_end      = rd_end_vld ? rd_end : '0;
  assign start_sum    = {1'b0, cur_interval} + {1'b0, time_count};

  assign wr_interval = exec && (cmd_r == swtt_pkg::CMD_SET_INTERVAL);
  assign wr_end      = exec && ((cmd_r == swtt_pkg::CMD_START) ||
                                (cmd_r == swtt_pkg::CMD_STOP));
  assign end_wdata   = (cmd_r == swtt_pkg::CMD_START) ? start_sum[TIME_WIDTH-1:0]
                                                      : time_count;

  // timer memories
  always_ff @(posedge clk) begin
    if (accept && in_range_in) begin
      rd_interval <= interval_mem[addr_in];
      rd_end      <= end_mem[addr_in];
    end
    if (wr_interval) begin
      interval_mem[addr_r] <= ival_r;
    end
    if (wr_end) begin
      end_mem[addr_r] <= end_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      interval_vld    <= '0;
      end_vld         <= '0;
      wrap_flags      <= '0;
      rd_interval_vld <= 1'b0;
      rd_end_vld      <= 1'b0;
    end else begin
      if (accept && in_range_in) begin
        rd_interval_vld <= interval_vld[addr_in];
        rd_end_vld      <= end_vld[addr_in];
      end
      if (wr_interval) begin
        interval_vld[addr_r] <= 1'b1;
      end
      if (wr_end) begin
        end_vld[addr_r] <= 1'b1;
      end
      if (exec && (cmd_r == swtt_pkg::CMD_START)) begin
        wrap_flags[addr_r] <= start_sum[TIME_WIDTH];
      end else if (exec && (cmd_r == swtt_pkg::CMD_CHECK) && wrap_flags[addr_r] &&
                   (cur_end > time_count)) begin
        wrap_flags[addr_r] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      half_tick    <= 1'b0;
      time_count   <= '0;
      done         <= 1'b0;
      cmd_r        <= '0;
      in_range_r   <= 1'b0;
    end else begin
      done <= (state == S_RESP);
      unique case (state)
        S_IDLE: begin
          if (start) begin
            cmd_r      <= command;
            addr_r     <= addr_in;
            in_range_r <= in_range_in;
            ival_r     <= TIME_WIDTH'(interval_value);
            state      <= S_EXEC;
          end
        end
        S_EXEC: begin
          expired_r <= exec && (cmd_r == swtt_pkg::CMD_CHECK) && !wrap_flags[addr_r] &&
                       (cur_end < time_count);
          base_time <= cur_end - cur_interval;
          if (cmd_r == swtt_pkg::CMD_TICK) begin
            half_tick <= !half_tick;
            if (!half_tick) begin
              time_count <= time_count + TIME_WIDTH'(1);
            end
          end
          state <= S_RESP;
        end
        S_RESP: begin
          expired      <= expired_r;
          elapsed_time <= (in_range_r && (cmd_r == swtt_pkg::CMD_ELAPSED))
                          ? 32'(time_count - base_time) : '0;
          current_time <= 32'(time_count);
          state        <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_accept_done: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##3 done)
    else $error("result strobe missing after accepted word");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  a_time_tick_only: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC) && (cmd_r != swtt_pkg::CMD_TICK) |=> $stable(time_count))
    else $error("system time moved on a non-tick command");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (wr_interval || wr_end) |-> (state == S_EXEC) && in_range_r)
    else $error("memory write outside execute");

  a_expired_check_only: assert property (@(posedge clk) disable iff (rst)
    done && expired |-> (cmd_r == swtt_pkg::CMD_CHECK))
    else $error("expired reported for a command other than check");

endmodule
